// File: rtl/eht_pkg.sv
`default_nettype none
package eht_pkg;

  localparam int unsigned KeyW = 32;
  localparam int unsigned ValW = 32;

  typedef enum logic [1:0] {
    REQ_ADD    = 2'd0,
    REQ_LOOKUP = 2'd1,
    REQ_REMOVE = 2'd2,
    REQ_NONE   = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_MISS  = 2'd1,
    ST_FULL  = 2'd2,
    ST_SPARE = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    CMD_IDLE,
    CMD_LOAD,
    CMD_BUCKET,
    CMD_SCAN,
    CMD_SPLIT_START,
    CMD_SPLIT_MOVE,
    CMD_SPLIT_DIR,
    CMD_DOUBLE,
    CMD_DOUBLE_END,
    CMD_WRITE_UPD,
    CMD_WRITE_NEW,
    CMD_CLEAR,
    CMD_FOUND
  } cmd_e;

  typedef struct packed {
    logic scan_done;
    logic found;
    logic has_room;
    logic has_free;
    logic can_split;
    logic can_double;
    logic walk_done;
  } dp_status_t;

endpackage
`default_nettype wire

// File: rtl/eht_datapath.sv
`default_nettype none
module eht_datapath #(
  parameter int unsigned MAX_GLOBAL_DEPTH = 4,
  parameter int unsigned BUCKET_SLOTS     = 4
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  eht_pkg::cmd_e            cmd_i,
  input  wire [31:0]               key_i,
  input  wire [31:0]               value_i,
  input  wire [2:0]                cap_i,
  output eht_pkg::dp_status_t      stat_o,
  output logic [31:0]              found_value_o
);
  import eht_pkg::*;

  localparam int unsigned DirSize  = 1 << MAX_GLOBAL_DEPTH;
  localparam int unsigned BW       = MAX_GLOBAL_DEPTH;
  localparam int unsigned SW       = (BUCKET_SLOTS > 1) ? $clog2(BUCKET_SLOTS) : 1;
  localparam int unsigned NumSlots = DirSize << SW;
  localparam int unsigned AW       = BW + SW;
  localparam int unsigned DW       = $clog2(MAX_GLOBAL_DEPTH + 1);
  localparam int unsigned CW       = $clog2(BUCKET_SLOTS + 1);
  localparam int unsigned NW       = $clog2(DirSize + 1);

  logic [BW-1:0]  dir_q [DirSize];
  logic [DW-1:0]  ldepth_q [DirSize];
  logic [DW-1:0]  gdepth_q;
  logic [NW-1:0]  alloc_q;
  logic [31:0]    skey_m [NumSlots];
  logic [31:0]    sval_m [NumSlots];
  logic [NumSlots-1:0] valid_q, valid_d;

  logic [31:0]    key_q, val_q;
  logic [BW-1:0]  bkt_q, nb_q;
  logic [DW-1:0]  ld_q;
  logic [SW:0]    s_q;
  logic [NW-1:0]  i_q;
  logic [CW-1:0]  used_q;
  logic           found_q, free_ok_q;
  logic [SW-1:0]  hit_q, free_q, to_q;
  logic [31:0]    rkey_q, rval_q, hval_q;
  logic [31:0]    found_q_v;

  logic [CW-1:0]  cap_eff;
  logic [BW-1:0]  idx_mask;
  logic [SW-1:0]  rd_slot, ev_slot;
  logic [AW-1:0]  rd_addr, ev_addr, to_addr;
  logic           s_end, ev_on, ev_valid, hit_now, mv_take;

  always_comb begin
    if (cap_i == 3'd0) begin
      cap_eff = CW'(1);
    end else if (32'(cap_i) > BUCKET_SLOTS) begin
      cap_eff = CW'(BUCKET_SLOTS);
    end else begin
      cap_eff = CW'(cap_i);
    end
  end

  // slot s_q is read while slot s_q-1 is evaluated from the registered data
  assign idx_mask = BW'((32'd1 << gdepth_q) - 32'd1);
  assign s_end    = (32'(s_q) == BUCKET_SLOTS);
  assign rd_slot  = s_q[SW-1:0];
  assign ev_slot  = SW'(s_q - (SW+1)'(1));
  assign rd_addr  = {bkt_q, rd_slot};
  assign ev_addr  = {bkt_q, ev_slot};
  assign to_addr  = {nb_q, to_q};
  assign ev_on    = (s_q != '0) && ((cmd_i == CMD_SCAN) || (cmd_i == CMD_SPLIT_MOVE));
  assign ev_valid = valid_q[ev_addr];
  assign hit_now  = ev_on && (cmd_i == CMD_SCAN) && ev_valid && (rkey_q == key_q)
                    && !found_q;
  assign mv_take  = ev_on && (cmd_i == CMD_SPLIT_MOVE) && ev_valid && rkey_q[ld_q];

  always_ff @(posedge clk_i) begin
    rkey_q <= skey_m[rd_addr];
    rval_q <= sval_m[rd_addr];
    if (cmd_i == CMD_WRITE_UPD) begin
      sval_m[{bkt_q, hit_q}] <= val_q;
    end else if (cmd_i == CMD_WRITE_NEW) begin
      skey_m[{bkt_q, free_q}] <= key_q;
      sval_m[{bkt_q, free_q}] <= val_q;
    end else if (mv_take) begin
      skey_m[to_addr] <= rkey_q;
      sval_m[to_addr] <= rval_q;
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (cmd_i == CMD_WRITE_NEW) begin
      valid_d[{bkt_q, free_q}] = 1'b1;
    end else if (cmd_i == CMD_CLEAR) begin
      valid_d[{bkt_q, hit_q}] = 1'b0;
    end else if (mv_take) begin
      valid_d[to_addr] = 1'b1;
      valid_d[ev_addr] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < DirSize; k++) begin
        dir_q[k]    <= '0;
        ldepth_q[k] <= '0;
      end
      gdepth_q  <= '0;
      alloc_q   <= NW'(1);
      valid_q   <= '0;
      key_q     <= '0;
      val_q     <= '0;
      bkt_q     <= '0;
      nb_q      <= '0;
      ld_q      <= '0;
      s_q       <= '0;
      i_q       <= '0;
      used_q    <= '0;
      found_q   <= 1'b0;
      free_ok_q <= 1'b0;
      hit_q     <= '0;
      free_q    <= '0;
      to_q      <= '0;
      hval_q    <= '0;
      found_q_v <= '0;
    end else begin
      valid_q <= valid_d;
      unique case (cmd_i)
        CMD_LOAD: begin
          key_q     <= key_i;
          val_q     <= value_i;
          found_q_v <= '0;
        end
        CMD_BUCKET: begin
          bkt_q     <= dir_q[key_q[BW-1:0] & idx_mask];
          s_q       <= '0;
          i_q       <= '0;
          used_q    <= '0;
          found_q   <= 1'b0;
          free_ok_q <= 1'b0;
        end
        CMD_SCAN: begin
          if (ev_on) begin
            if (ev_valid) begin
              used_q <= used_q + CW'(1);
            end else if (!free_ok_q) begin
              free_ok_q <= 1'b1;
              free_q    <= ev_slot;
            end
          end
          if (hit_now) begin
            found_q <= 1'b1;
            hit_q   <= ev_slot;
            hval_q  <= rval_q;
          end
          if (!s_end) begin
            s_q <= s_q + (SW+1)'(1);
          end
        end
        CMD_SPLIT_START: begin
          ld_q            <= ldepth_q[bkt_q];
          nb_q            <= BW'(alloc_q);
          alloc_q         <= alloc_q + NW'(1);
          ldepth_q[bkt_q] <= ldepth_q[bkt_q] + DW'(1);
          s_q             <= '0;
          i_q             <= '0;
          to_q            <= '0;
        end
        CMD_SPLIT_MOVE: begin
          ldepth_q[nb_q] <= ld_q + DW'(1);
          if (mv_take) begin
            to_q <= to_q + SW'(1);
          end
          if (!s_end) begin
            s_q <= s_q + (SW+1)'(1);
          end
        end
        CMD_SPLIT_DIR: begin
          if (dir_q[i_q[BW-1:0]] == bkt_q && i_q[ld_q]) begin
            dir_q[i_q[BW-1:0]] <= nb_q;
          end
          i_q <= i_q + NW'(1);
        end
        CMD_DOUBLE: begin
          dir_q[BW'(i_q + (NW'(1) << gdepth_q))] <= dir_q[i_q[BW-1:0]];
          i_q <= i_q + NW'(1);
        end
        CMD_DOUBLE_END: begin
          gdepth_q <= gdepth_q + DW'(1);
          i_q      <= '0;
        end
        CMD_FOUND: begin
          found_q_v <= hval_q;
        end
        default: begin
        end
      endcase
    end
  end

  assign found_value_o = found_q_v;

  always_comb begin
    stat_o.scan_done  = s_end;
    stat_o.found      = found_q;
    stat_o.has_room   = (used_q < cap_eff);
    stat_o.has_free   = free_ok_q;
    stat_o.can_split  = (ldepth_q[bkt_q] < gdepth_q) && (32'(alloc_q) < DirSize);
    stat_o.can_double = (32'(gdepth_q) < MAX_GLOBAL_DEPTH);
    if (cmd_i == CMD_SPLIT_MOVE) begin
      stat_o.walk_done = s_end;
    end else begin
      stat_o.walk_done = (32'(i_q) >= (32'd1 << gdepth_q) - 32'd1);
    end
  end

endmodule
`default_nettype wire

// File: rtl/eht_ctrl.sv
`default_nettype none
module eht_ctrl (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  wire [1:0]            req_type_i,
  output logic                 out_valid,
  input  wire                  out_stall,
  output logic [1:0]           status_o,
  input  eht_pkg::dp_status_t  stat_i,
  output eht_pkg::cmd_e        cmd_o
);
  import eht_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_BKT, S_SCAN, S_DECIDE, S_SPLIT, S_MOVE, S_SDIR, S_DBL, S_DEND,
    S_FINISH, S_OUT
  } state_e;

  state_e   state_q, state_d;
  req_e     req_q;
  logic     out_valid_q;
  logic [1:0] status_q, status_d;
  logic     accept;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = !(state_q == S_IDLE) || out_valid_q;
  assign out_valid = out_valid_q;
  assign status_o  = status_q;

  always_comb begin
    cmd_o    = CMD_IDLE;
    state_d  = state_q;
    status_d = status_q;
    unique case (state_q)
      S_IDLE: if (accept) begin
        cmd_o = CMD_LOAD; state_d = S_BKT;
      end
      S_BKT: begin
        cmd_o = CMD_BUCKET; state_d = S_SCAN;
      end
      S_SCAN: begin
        cmd_o = CMD_SCAN;
        if (stat_i.scan_done) state_d = S_DECIDE;
      end
      S_DECIDE: begin
        state_d = S_OUT;
        if (req_q == REQ_LOOKUP) begin
          status_d = stat_i.found ? ST_OK : ST_MISS;
          if (stat_i.found) cmd_o = CMD_FOUND;
        end else if (req_q == REQ_REMOVE) begin
          status_d = stat_i.found ? ST_OK : ST_MISS;
          if (stat_i.found) cmd_o = CMD_CLEAR;
        end else if (req_q == REQ_ADD) begin
          status_d = ST_OK;
          if (stat_i.found) begin
            cmd_o = CMD_WRITE_UPD;
          end else if (stat_i.has_room) begin
            if (stat_i.has_free) cmd_o = CMD_WRITE_NEW;
            else status_d = ST_FULL;
          end else if (stat_i.can_split) begin
            state_d = S_SPLIT;
          end else if (stat_i.can_double) begin
            state_d = S_DBL;
          end else begin
            status_d = ST_FULL;
          end
        end else begin
          status_d = ST_MISS;
        end
      end
      S_SPLIT: begin
        cmd_o = CMD_SPLIT_START; state_d = S_MOVE;
      end
      S_MOVE: begin
        cmd_o = CMD_SPLIT_MOVE;
        if (stat_i.walk_done) state_d = S_SDIR;
      end
      S_SDIR: begin
        cmd_o = CMD_SPLIT_DIR;
        if (stat_i.walk_done) state_d = S_BKT;
      end
      S_DBL: begin
        cmd_o = CMD_DOUBLE;
        if (stat_i.walk_done) state_d = S_DEND;
      end
      S_DEND: begin
        cmd_o = CMD_DOUBLE_END; state_d = S_BKT;
      end
      S_FINISH: state_d = S_OUT;
      S_OUT: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      req_q       <= REQ_NONE;
      out_valid_q <= 1'b0;
      status_q    <= ST_OK;
    end else begin
      state_q  <= state_d;
      status_q <= status_d;
      if (accept) req_q <= req_e'(req_type_i);
      if (state_q == S_OUT) out_valid_q <= 1'b1;
      else if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
    end
  end

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> in_stall) else $error("accept while busy");
  a_out_after_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT) |=> out_valid_q) else $error("result not raised");
  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (state_q == S_IDLE)) else $error("result while busy");

endmodule
`default_nettype wire

// File: rtl/extendible_hash_table.sv
`default_nettype none
// Extendible-hashing key/value store, one request in flight at a time. A request
// scans the bucket slots serially through the single slot memory read port, and
// the next request is taken only once the previous result has left the output.
// An add that must split a bucket walks the bucket slots and then every live
// directory slot; a doubling copies each directory slot. Both then scan again.
// bucket_capacity may only be written while no request is in flight.
module extendible_hash_table #(
  parameter int unsigned MAX_GLOBAL_DEPTH = 4,
  parameter int unsigned BUCKET_SLOTS     = 4
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid,
  output logic               in_stall,
  input  wire  [1:0]         req_type_i,
  input  wire signed [31:0]  key_i,
  input  wire signed [31:0]  value_i,
  output logic               out_valid,
  input  wire                out_stall,
  output logic [1:0]         status_o,
  output logic signed [31:0] found_value_o,
  input  wire                cfg_we_i,
  input  wire  [2:0]         cfg_wdata_i
);
  import eht_pkg::*;

  logic [2:0]  cap_q;
  cmd_e        cmd;
  dp_status_t  stat;
  logic [31:0] fv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cap_q <= 3'd4;
    else if (cfg_we_i) cap_q <= cfg_wdata_i;
  end

  eht_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid, .in_stall, .req_type_i,
    .out_valid, .out_stall, .status_o, .stat_i(stat), .cmd_o(cmd)
  );

  eht_datapath #(.MAX_GLOBAL_DEPTH(MAX_GLOBAL_DEPTH), .BUCKET_SLOTS(BUCKET_SLOTS)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .key_i(key_i), .value_i(value_i),
    .cap_i(cap_q), .stat_o(stat), .found_value_o(fv)
  );

  assign found_value_o = signed'(fv);

endmodule
`default_nettype wire

// File: test/tb_extendible_hash_table.sv
`timescale 1ns / 1ps
module tb_extendible_hash_table;
  import eht_pkg::*;

  localparam int unsigned DirSize  = 16;
  localparam int unsigned BktSlots = 4;
  localparam int unsigned NumSlots = DirSize * BktSlots;
  localparam int unsigned MaxDepth = 4;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] found;
  } answer_t;

  // predicted hash table plus queue of pending answers
  class hash_scoreboard;
    logic [2:0]  capacity;
    logic [3:0]  dir [DirSize];
    int unsigned gdepth;
    int unsigned ldepth [DirSize];
    int unsigned nbuckets;
    logic [31:0] keys [NumSlots];
    logic [31:0] vals [NumSlots];
    bit          live [NumSlots];
    answer_t     pending [$];
    int          errors;

    function new();
      capacity = 3'd4;
      gdepth   = 0;
      nbuckets = 1;
      errors   = 0;
      foreach (dir[i]) dir[i] = '0;
      foreach (ldepth[i]) ldepth[i] = 0;
      foreach (live[i]) begin
        live[i] = 0;
        keys[i] = '0;
        vals[i] = '0;
      end
    endfunction

    function int unsigned eff_cap();
      if (capacity == 0) return 1;
      if (capacity > BktSlots) return BktSlots;
      return capacity;
    endfunction

    function int unsigned bucket_of(logic [31:0] k);
      int unsigned m;
      m = (1 << gdepth) - 1;
      return dir[k & m];
    endfunction

    function int find_slot(int unsigned b, logic [31:0] k);
      for (int s = 0; s < BktSlots; s++)
        if (live[b*BktSlots+s] && keys[b*BktSlots+s] == k) return b*BktSlots+s;
      return -1;
    endfunction

    function int free_of(int unsigned b);
      for (int s = 0; s < BktSlots; s++)
        if (!live[b*BktSlots+s]) return b*BktSlots+s;
      return -1;
    endfunction

    function int unsigned used_of(int unsigned b);
      int unsigned n;
      n = 0;
      for (int s = 0; s < BktSlots; s++) if (live[b*BktSlots+s]) n++;
      return n;
    endfunction

    function void split(int unsigned b);
      int unsigned d, nb, fr;
      int to;
      d  = ldepth[b];
      nb = nbuckets;
      nbuckets++;
      ldepth[b]  = d + 1;
      ldepth[nb] = d + 1;
      for (int s = 0; s < BktSlots; s++) begin
        fr = b*BktSlots + s;
        if (live[fr] && keys[fr][d]) begin
          to = free_of(nb);
          if (to >= 0) begin
            keys[to] = keys[fr];
            vals[to] = vals[fr];
            live[to] = 1;
            live[fr] = 0;
          end
        end
      end
      for (int i = 0; i < (1 << gdepth); i++)
        if (dir[i] == b && ((i >> d) & 1)) dir[i] = nb;
    endfunction

    function int make_room(logic [31:0] k);
      int unsigned b, half;
      forever begin
        b = bucket_of(k);
        if (used_of(b) < eff_cap()) return b;
        if (ldepth[b] < gdepth && nbuckets < DirSize) split(b);
        else if (gdepth < MaxDepth) begin
          half = 1 << gdepth;
          for (int i = 0; i < half; i++) dir[i+half] = dir[i];
          gdepth++;
        end else return -1;
      end
    endfunction

    function void note_request(req_e rq, logic [31:0] k, logic [31:0] v);
      answer_t a;
      int p, nb, s;
      a.status = ST_MISS;
      a.found  = '0;
      p = find_slot(bucket_of(k), k);
      case (rq)
        REQ_ADD: begin
          if (p >= 0) begin
            vals[p] = v;
            a.status = ST_OK;
          end else begin
            nb = make_room(k);
            s  = (nb < 0) ? -1 : free_of(nb);
            if (s < 0) a.status = ST_FULL;
            else begin
              keys[s] = k;
              vals[s] = v;
              live[s] = 1;
              a.status = ST_OK;
            end
          end
        end
        REQ_LOOKUP: if (p >= 0) begin
          a.status = ST_OK;
          a.found  = vals[p];
        end
        REQ_REMOVE: if (p >= 0) begin
          live[p] = 0;
          a.status = ST_OK;
        end
        default: ;
      endcase
      pending.push_back(a);
    endfunction

    function void check_answer(logic [1:0] st, logic [31:0] fv);
      answer_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected answer status %0d value %h", $time, st, fv);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (st !== e.status) begin
        $display("%0t: status expected %0d actual %0d", $time, e.status, st);
        errors++;
      end
      if (fv !== e.found) begin
        $display("%0t: found_value expected %h actual %h", $time, e.found, fv);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        in_valid = 0;
  logic        in_stall;
  logic [1:0]  req_type_i = '0;
  logic [31:0] key_i = '0;
  logic [31:0] value_i = '0;
  logic        out_valid;
  logic        out_stall = 0;
  logic [1:0]  status_o;
  logic [31:0] found_value_o;
  logic        cfg_we_i = 0;
  logic [2:0]  cfg_wdata_i = '0;

  hash_scoreboard sb = new();
  bit quiet;
  bit hold_long;

  extendible_hash_table u_dut (
    .clk_i, .rst_ni, .in_valid, .in_stall, .req_type_i, .key_i, .value_i,
    .out_valid, .out_stall, .status_o, .found_value_o, .cfg_we_i, .cfg_wdata_i
  );

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  initial begin
    #50ms;
    $display("** extendible_hash_table: FAILED **");
    $finish;
  end

  // receiver: random stall bursts, one long hold-off on request
  initial begin
    int n;
    forever begin
      @(posedge clk_i);
      if (hold_long) begin
        out_stall <= 1;
        repeat (300) @(posedge clk_i);
        out_stall <= 0;
        hold_long = 0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 5);
        out_stall <= 1;
        repeat (n) @(posedge clk_i);
        out_stall <= 0;
      end
    end
  end

  always @(posedge clk_i)
    if (rst_ni && out_valid && !out_stall) sb.check_answer(status_o, found_value_o);

  task automatic send(req_e rq, logic [31:0] k, logic [31:0] v);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_valid   <= 1;
    req_type_i <= rq;
    key_i      <= k;
    value_i    <= v;
    do @(posedge clk_i); while (in_stall);
    sb.note_request(rq, k, v);
  endtask

  task automatic set_capacity(logic [2:0] c);
    in_valid <= 0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    cfg_we_i    <= 1;
    cfg_wdata_i <= c;
    @(posedge clk_i);
    cfg_we_i <= 0;
    sb.capacity = c;
  endtask

  function automatic logic [31:0] pick_key(int unsigned mode);
    // mostly a small key pool so hits, updates and splits happen
    case (mode)
      0: return $urandom_range(0, 40);
      1: return {2'($urandom_range(0, 3)), 26'h0, 4'($urandom_range(0, 15))};
      default: return $urandom;
    endcase
  endfunction

  task automatic random_phase(int unsigned count, int unsigned mode);
    req_e rq;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 19))
        0:            rq = REQ_NONE;
        1, 2, 3, 4:   rq = REQ_REMOVE;
        5, 6, 7, 8, 9, 10: rq = REQ_LOOKUP;
        default:      rq = REQ_ADD;
      endcase
      send(rq, pick_key(($urandom_range(0, 9) == 0) ? 2 : mode), $urandom);
    end
  endtask

  initial begin
    int unsigned waited;
    quiet = 0;
    hold_long = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed
    send(REQ_LOOKUP, 32'h0, 32'h0);
    send(REQ_ADD, 32'h8000_0000, 32'h7fff_ffff);
    send(REQ_ADD, 32'h7fff_ffff, 32'h8000_0000);
    send(REQ_ADD, 32'hffff_ffff, 32'hffff_ffff);
    send(REQ_ADD, 32'h0, 32'h0);
    send(REQ_LOOKUP, 32'h8000_0000, 32'h1234);
    send(REQ_ADD, 32'h7fff_ffff, 32'h5555_aaaa);
    send(REQ_LOOKUP, 32'h7fff_ffff, 32'h0);
    send(REQ_ADD, 32'h1, 32'h11);
    send(REQ_ADD, 32'h2, 32'h22);
    send(REQ_REMOVE, 32'h2, 32'h0);
    send(REQ_REMOVE, 32'h2, 32'h0);
    send(REQ_LOOKUP, 32'h2, 32'h0);
    send(REQ_NONE, 32'h1, 32'h0);
    send(REQ_LOOKUP, 32'h1, 32'h0);
    set_capacity(3'd1);
    // same low bits force repeated doubling until full at maximum depth
    for (int i = 0; i < 6; i++) send(REQ_ADD, 32'h10 * i + 32'h100, i);
    send(REQ_LOOKUP, 32'h100, 32'h0);

    set_capacity(3'd0);
    random_phase(150, 1);
    set_capacity(3'd7);
    hold_long = 1;
    random_phase(250, 0);
    set_capacity(3'd2);
    random_phase(250, 0);
    set_capacity(3'd3);
    random_phase(250, 1);
    set_capacity(3'd4);
    quiet = 1;
    random_phase(300, 0);
    in_valid <= 0;

    waited = 0;
    while (sb.pending.size() != 0 && waited < 100000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (100) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("** extendible_hash_table: PASSED **");
    else
      $display("** extendible_hash_table: FAILED **");
    $finish;
  end
endmodule
